### rtl/core/egc_pkg.sv
// Shared constants, request codes and control structs of the Euler graph checker.
// Used by the channel interfaces, the walk engine and the top level.
package egc_pkg;

  localparam int EGC_MAX_VERTICES = 64;
  localparam int REQ_W = 2;
  localparam int VTX_W = 6;
  localparam int CFG_W = 7;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd2;

  typedef struct packed {
    logic             start;
    logic [REQ_W-1:0] op;
    logic             take;
  } egc_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic connected;
    logic all_even;
  } egc_stat_t;

endpackage

### rtl/core/egc_if.sv
// Valid/ready channel interfaces for requests and results of the Euler graph checker.
// Depends on egc_pkg for field widths.
interface egc_req_if import egc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, req_type, vertex_a, vertex_b, input ready);
  modport sink (input valid, req_type, vertex_a, vertex_b, output ready);
endinterface

interface egc_rsp_if ();
  logic valid;
  logic ready;
  logic is_euler;
  logic connected;
  logic all_even;
  logic bad_edge_seen;

  modport source (output valid, is_euler, connected, all_even, bad_edge_seen, input ready);
  modport sink (input valid, is_euler, connected, all_even, bad_edge_seen, output ready);
endinterface

### rtl/core/euler_graph_checker.sv
// Top level of the Euler graph checker: vertex count register, bad-edge flag,
// request decode and result register. Depends on egc_pkg, egc_if.sv, egc_engine.
//
// Usage: requests arrive on a valid/ready channel. A clear request empties the
// adjacency matrix and the bad-edge flag; an add request sets both symmetric bits
// of one edge; an evaluate request yields one result (is_euler, connected,
// all_even, bad_edge_seen) on the result channel. Code 3 and clear/add give none.
// An add with an endpoint at or above the vertex count sets the bad-edge flag.
// An add writes one bit on acceptance and its symmetric bit in S_ADD2; a clear
// wipes one matrix row per cycle. An evaluate scans the rows, reading each one
// through the single matrix read port (S_SCAN_RD) and testing it (S_SCAN_EV),
// then walks, testing one column per cycle of each popped row. Requests are
// refused while an operation is in progress. After reset the matrix is wiped
// before the first request is taken. A finished result sits in the output
// register until taken; the next request is accepted meanwhile, but a second
// result waits inside the engine, holding request ready low, until the first
// is taken. vertex_count is written through cfg_wr_en/cfg_wr_data; the user is
// to write it only while idle, which the block itself does not enforce.
module euler_graph_checker import egc_pkg::*; #(
  parameter int MAX_VERTICES = EGC_MAX_VERTICES
) (
  input  logic             clk,
  input  logic             rst,
  egc_req_if.sink          request,
  egc_rsp_if.source        result,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] vertex_count;
  logic             bad_flag;
  logic [NW-1:0]    count_ext;
  logic [NW-1:0]    live_ext;
  logic [CNT_W-1:0] live_count;
  logic             accept;
  logic             in_range;
  logic             take;
  logic             out_valid;
  egc_cmd_t         cmd;
  egc_stat_t        stat;

  assign count_ext  = NW'(vertex_count);
  assign live_ext   = (count_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : count_ext;
  assign live_count = live_ext[CNT_W-1:0];

  assign request.ready = stat.ready;
  assign accept        = request.valid && request.ready;
  assign in_range      = (NW'(request.vertex_a) < live_ext) &&
                         (NW'(request.vertex_b) < live_ext);
  assign take          = stat.done && (!out_valid || result.ready);

  assign cmd.start = accept && ((request.req_type == REQ_CLEAR) ||
                                (request.req_type == REQ_EVAL) ||
                                (request.req_type == REQ_ADD && in_range));
  assign cmd.op    = request.req_type;
  assign cmd.take  = take;

  egc_engine #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .vertex_a  (VW'(request.vertex_a)),
    .vertex_b  (VW'(request.vertex_b)),
    .live_count(live_count),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      bad_flag     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (accept && request.req_type == REQ_CLEAR) begin
        bad_flag <= 1'b0;
      end else if (accept && request.req_type == REQ_ADD && !in_range) begin
        bad_flag <= 1'b1;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.is_euler      <= stat.connected & stat.all_even;
      result.connected     <= stat.connected;
      result.all_even      <= stat.all_even;
      result.bad_edge_seen <= bad_flag;
    end
  end

  assign result.valid = out_valid;

  a_ready_not_done: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !stat.done)
    else $error("engine ready and done at once");

  a_eval_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && request.req_type == REQ_EVAL) |=> !request.ready)
    else $error("evaluate request did not occupy the engine");

  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.done))
    else $error("result raised without a finished evaluation");

  a_clear_drops_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && request.req_type == REQ_CLEAR) |=> !bad_flag)
    else $error("bad-edge flag survived a clear");

endmodule

### rtl/core/egc_engine.sv
// Adjacency matrix memory, walk stack memory and the sequencer that clears,
// adds edges and evaluates the graph. Depends on egc_pkg.
module egc_engine import egc_pkg::*; #(
  parameter int MAX_VERTICES = EGC_MAX_VERTICES,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  egc_cmd_t         cmd,
  input  logic [VW-1:0]    vertex_a,
  input  logic [VW-1:0]    vertex_b,
  input  logic [CNT_W-1:0] live_count,
  output egc_stat_t        stat
);

  localparam logic [3:0] S_WIPE    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ADD2    = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_EV = 4'd4;
  localparam logic [3:0] S_POP     = 4'd5;
  localparam logic [3:0] S_POPW    = 4'd6;
  localparam logic [3:0] S_ROW     = 4'd7;
  localparam logic [3:0] S_COL     = 4'd8;
  localparam logic [3:0] S_CHECK   = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]              state;
  logic [VW-1:0]           wipe_idx;
  logic [VW-1:0]           add_row;
  logic [VW-1:0]           add_col;
  logic [CNT_W-1:0]        n_reg;
  logic [MAX_VERTICES-1:0] live;
  logic [MAX_VERTICES-1:0] live_next;
  logic [CNT_W-1:0]        idx;
  logic                    found;
  logic [VW-1:0]           start;
  logic                    all_even;
  logic                    connected;
  logic [MAX_VERTICES-1:0] has_edge;
  logic [MAX_VERTICES-1:0] visited;
  logic [CNT_W-1:0]        sp;
  logic [CNT_W-1:0]        sp_m1;
  logic [MAX_VERTICES-1:0] row_reg;
  logic [MAX_VERTICES-1:0] scan_row;
  logic                    push;

  logic [MAX_VERTICES-1:0] adj [MAX_VERTICES];
  logic                    adj_we;
  logic [VW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wmask;
  logic                    adj_wbit;
  logic [VW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] adj_rd;

  logic [VW-1:0]           stk [MAX_VERTICES];
  logic                    stk_we;
  logic [VW-1:0]           stk_waddr;
  logic [VW-1:0]           stk_wdata;
  logic [VW-1:0]           stk_raddr;
  logic [VW-1:0]           stk_rd;

  always_ff @(posedge clk) begin
    if (adj_we) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
        if (adj_wmask[k]) begin
          adj[adj_waddr][k] <= adj_wbit;
        end
      end
    end
    adj_rd <= adj[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
    stk_rd <= stk[stk_raddr];
  end

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      live_next[k] = (CNT_W'(k) < live_count);
    end
  end

  assign sp_m1    = sp - CNT_W'(1);
  assign scan_row = adj_rd & live;
  assign push     = (idx != n_reg) && row_reg[0] && !visited[idx[VW-1:0]] &&
                    (sp < CNT_W'(MAX_VERTICES));

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = wipe_idx;
    adj_wmask = '1;
    adj_wbit  = 1'b0;
    adj_raddr = idx[VW-1:0];
    stk_we    = 1'b0;
    stk_waddr = sp[VW-1:0];
    stk_wdata = idx[VW-1:0];
    stk_raddr = sp_m1[VW-1:0];
    unique case (state)
      S_WIPE: begin
        adj_we = 1'b1;
      end
      S_IDLE: begin
        if (cmd.start && cmd.op == REQ_ADD) begin
          adj_we    = 1'b1;
          adj_waddr = vertex_a;
          adj_wmask = MAX_VERTICES'(1) << vertex_b;
          adj_wbit  = 1'b1;
        end
      end
      S_ADD2: begin
        adj_we    = 1'b1;
        adj_waddr = add_row;
        adj_wmask = MAX_VERTICES'(1) << add_col;
        adj_wbit  = 1'b1;
      end
      S_SCAN_RD: begin
        if (idx == n_reg && found) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = start;
        end
      end
      S_POPW: begin
        adj_raddr = stk_rd;
      end
      S_COL: begin
        stk_we = push;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_WIPE;
      wipe_idx <= '0;
    end else begin
      unique case (state)
        S_WIPE: begin
          wipe_idx <= wipe_idx + VW'(1);
          if (wipe_idx == VW'(MAX_VERTICES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.start) begin
            unique case (cmd.op)
              REQ_CLEAR: begin
                wipe_idx <= '0;
                state    <= S_WIPE;
              end
              REQ_ADD: begin
                add_row <= vertex_b;
                add_col <= vertex_a;
                state   <= S_ADD2;
              end
              REQ_EVAL: begin
                n_reg    <= live_count;
                live     <= live_next;
                idx      <= '0;
                found    <= 1'b0;
                all_even <= 1'b1;
                has_edge <= '0;
                sp       <= '0;
                state    <= S_SCAN_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD2: begin
          state <= S_IDLE;
        end
        S_SCAN_RD: begin
          if (idx == n_reg) begin
            if (found) begin
              sp      <= CNT_W'(1);
              visited <= MAX_VERTICES'(1) << start;
              state   <= S_POP;
            end else begin
              connected <= 1'b1;
              state     <= S_DONE;
            end
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (^scan_row) begin
            all_even <= 1'b0;
          end
          if (|scan_row) begin
            has_edge[idx[VW-1:0]] <= 1'b1;
            if (!found) begin
              found <= 1'b1;
              start <= idx[VW-1:0];
            end
          end
          idx   <= idx + CNT_W'(1);
          state <= S_SCAN_RD;
        end
        S_POP: begin
          if (sp == '0) begin
            state <= S_CHECK;
          end else begin
            sp    <= sp_m1;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          state <= S_ROW;
        end
        S_ROW: begin
          row_reg <= scan_row;
          idx     <= '0;
          state   <= S_COL;
        end
        S_COL: begin
          if (idx == n_reg) begin
            state <= S_POP;
          end else begin
            if (push) begin
              visited[idx[VW-1:0]] <= 1'b1;
              sp <= sp + CNT_W'(1);
            end
            row_reg <= row_reg >> 1;
            idx     <= idx + CNT_W'(1);
          end
        end
        S_CHECK: begin
          connected <= ~|(has_edge & ~visited);
          state     <= S_DONE;
        end
        S_DONE: begin
          if (cmd.take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.ready     = (state == S_IDLE);
  assign stat.done      = (state == S_DONE);
  assign stat.connected = connected;
  assign stat.all_even  = all_even;

endmodule

### verif/tb_euler_graph_checker.sv
// Testbench for euler_graph_checker: drives clear, add-edge, evaluate and code 3
// requests and checks every result against a graph predictor kept in the bench.
// Depends on egc_pkg and the channel interfaces in egc_if.sv.
module tb_euler_graph_checker;
  import egc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 500;
  localparam int QUIET_LIMIT = 20000;
  localparam int RANDOM_STOP = 1230;

  typedef struct packed {
    logic is_euler;
    logic connected;
    logic all_even;
    logic bad_edge_seen;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  egc_req_if request_ch ();
  egc_rsp_if result_ch ();

  bit [63:0]    link_rows [EGC_MAX_VERTICES];
  bit           stray_edge_seen;
  int unsigned  cfg_vertices;
  verdict_t     expected_verdicts [$];
  int unsigned  order [EGC_MAX_VERTICES];
  int           sent_count = 0;
  int           mismatch_count = 0;
  bit           calm_mode = 1'b0;
  int           hold_token = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           pause_left = 0;
  int           quiet_cycles = 0;

  euler_graph_checker uut (
    .clk         (clk),
    .rst         (rst),
    .request     (request_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned live_vertices();
    return (cfg_vertices > EGC_MAX_VERTICES) ? EGC_MAX_VERTICES : cfg_vertices;
  endfunction

  function automatic int unsigned at_most(int unsigned x, int unsigned y);
    return (x < y) ? x : y;
  endfunction

  function automatic verdict_t judge_graph();
    bit [63:0]   live;
    bit [63:0]   busy;
    bit [63:0]   reached;
    bit [63:0]   grown;
    int unsigned n;
    verdict_t    v;
    n = live_vertices();
    live = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    busy = '0;
    v.all_even = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ((link_rows[i] & live) != 0) busy[i] = 1'b1;
      if ($countones(link_rows[i] & live) % 2 == 1) v.all_even = 1'b0;
    end
    // start from the lowest vertex that has an edge
    reached = busy & (~busy + 64'd1);
    do begin
      grown = reached;
      for (int i = 0; i < n; i++) begin
        if (grown[i]) reached |= link_rows[i] & live;
      end
    end while (reached != grown);
    v.connected = ((busy & ~reached) == 0);
    v.is_euler = v.connected & v.all_even;
    v.bad_edge_seen = stray_edge_seen;
    return v;
  endfunction

  function automatic void apply_request(logic [REQ_W-1:0] kind, logic [VTX_W-1:0] a,
                                        logic [VTX_W-1:0] b);
    int unsigned n;
    n = live_vertices();
    case (kind)
      REQ_CLEAR: begin
        foreach (link_rows[i]) link_rows[i] = '0;
        stray_edge_seen = 1'b0;
      end
      REQ_ADD: begin
        if (a >= n || b >= n) begin
          stray_edge_seen = 1'b1;
        end else begin
          link_rows[a][b] = 1'b1;
          link_rows[b][a] = 1'b1;
        end
      end
      REQ_EVAL: expected_verdicts.push_back(judge_graph());
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [REQ_W-1:0] kind, int unsigned a, int unsigned b);
    logic [VTX_W-1:0] a_bits;
    logic [VTX_W-1:0] b_bits;
    a_bits = VTX_W'(a);
    b_bits = VTX_W'(b);
    if (!calm_mode && $urandom_range(0, 4) == 0) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    request_ch.valid    <= 1'b1;
    request_ch.req_type <= kind;
    request_ch.vertex_a <= a_bits;
    request_ch.vertex_b <= b_bits;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    apply_request(kind, a_bits, b_bits);
    if (kind != REQ_UNUSED) sent_count++;
  endtask

  task automatic send_evaluate();
    send_request(REQ_EVAL, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic send_clear();
    send_request(REQ_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic settle_idle();
    request_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(int unsigned count);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(count);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_vertices = count;
  endtask

  function automatic int unsigned pick_vertex(int unsigned n);
    return (n == 0) ? $urandom_range(0, 63) : $urandom_range(0, at_most(n, 64) - 1);
  endfunction

  task automatic shuffle_vertices(int unsigned n);
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < EGC_MAX_VERTICES; i++) order[i] = i;
    for (int i = int'(n) - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endtask

  task automatic add_cycle(int unsigned first, int unsigned len);
    int unsigned u;
    int unsigned w;
    for (int i = 0; i < len; i++) begin
      u = order[first + i];
      w = order[first + (i + 1) % len];
      if ($urandom_range(0, 1)) send_request(REQ_ADD, u, w);
      else send_request(REQ_ADD, w, u);
    end
  endtask

  task automatic send_noise(int unsigned count);
    int unsigned r;
    int unsigned n;
    n = live_vertices();
    repeat (count) begin
      r = $urandom_range(0, 15);
      if (r == 0) send_clear();
      else if (r <= 2) send_evaluate();
      else if (r == 3) send_request(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
      else send_request(REQ_ADD, r[0] ? pick_vertex(n) : $urandom_range(0, 63),
                        r[1] ? pick_vertex(n) : $urandom_range(0, 63));
    end
  endtask

  task automatic build_and_judge(int unsigned n);
    int unsigned shape;
    int unsigned k1;
    int unsigned k2;
    int unsigned v;
    send_clear();
    shuffle_vertices(n);
    shape = $urandom_range(0, 4);
    if ((shape == 0 && n < 3) || (shape == 1 && n < 5) || (shape == 2 && n < 2) ||
        (shape == 3 && n < 6))
      shape = 4;
    case (shape)
      0: add_cycle(0, $urandom_range(3, at_most(n, 9)));
      1: begin
        k1 = $urandom_range(3, at_most(n - 2, 6));
        k2 = $urandom_range(3, at_most(n - k1 + 1, 6));
        add_cycle(0, k1);
        order[k1 - 1] = order[0];
        add_cycle(k1 - 1, k2);
      end
      2: begin
        k1 = $urandom_range(2, at_most(n, 9));
        for (int i = 0; i + 1 < k1; i++) send_request(REQ_ADD, order[i], order[i + 1]);
      end
      3: begin
        k1 = $urandom_range(3, at_most(n - 3, 6));
        k2 = $urandom_range(3, at_most(n - k1, 6));
        add_cycle(0, k1);
        add_cycle(k1, k2);
      end
      default: repeat ($urandom_range(1, 10)) send_request(REQ_ADD, pick_vertex(n), pick_vertex(n));
    endcase
    case ($urandom_range(0, 7))
      0: send_request(REQ_ADD, pick_vertex(n), pick_vertex(n));
      1: if (n < 64) send_request(REQ_ADD, $urandom_range(n, 63), pick_vertex(n));
      2: begin
        v = pick_vertex(n);
        send_request(REQ_ADD, v, v);
      end
      default: ;
    endcase
    send_evaluate();
    if ($urandom_range(0, 4) == 0) send_evaluate();
  endtask

  task automatic test_empty_graph();
    set_vertex_count(0);
    send_evaluate();
    send_request(REQ_ADD, 0, 0);
    send_request(REQ_ADD, 63, 63);
    send_evaluate();
    send_request(REQ_UNUSED, 63, 63);
    send_evaluate();
    send_request(REQ_CLEAR, 0, 0);
    send_evaluate();
  endtask

  task automatic test_self_loops_at_limit();
    settle_idle();
    set_vertex_count(127);
    send_request(REQ_CLEAR, 63, 63);
    send_request(REQ_ADD, 63, 63);
    send_evaluate();
    send_request(REQ_ADD, 0, 63);
    send_evaluate();
    send_request(REQ_ADD, 0, 0);
    send_evaluate();
  endtask

  task automatic test_shrunk_count();
    settle_idle();
    set_vertex_count(4);
    send_evaluate();
    send_request(REQ_ADD, 1, 2);
    send_evaluate();
    send_request(REQ_ADD, 4, 0);
    send_evaluate();
    send_clear();
    send_evaluate();
  endtask

  task automatic test_full_size();
    settle_idle();
    set_vertex_count(64);
    send_clear();
    shuffle_vertices(64);
    add_cycle(0, 64);
    send_evaluate();
    send_request(REQ_ADD, order[0], order[32]);
    send_evaluate();
    settle_idle();
    set_vertex_count(100);
    send_evaluate();
    build_and_judge(64);
  endtask

  task automatic test_result_backpressure();
    settle_idle();
    set_vertex_count(6);
    send_clear();
    shuffle_vertices(6);
    add_cycle(0, 6);
    hold_token <= hold_token + 1;
    repeat (8) begin
      send_evaluate();
      send_request(REQ_ADD, pick_vertex(6), pick_vertex(6));
    end
  endtask

  task automatic test_random_graphs();
    int unsigned r;
    while (sent_count < RANDOM_STOP) begin
      settle_idle();
      r = $urandom_range(0, 9);
      if (r == 0) set_vertex_count($urandom_range(0, 2));
      else if (r == 1) set_vertex_count(32);
      else if (r == 2) set_vertex_count($urandom_range(17, 24));
      else set_vertex_count($urandom_range(3, 16));
      if ($urandom_range(0, 2) == 0) send_noise($urandom_range(2, 8));
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 4) != 0) build_and_judge(live_vertices());
        else send_noise($urandom_range(3, 12));
      end
    end
  endtask

  task automatic test_steady_stream();
    settle_idle();
    calm_mode <= 1'b1;
    set_vertex_count(10);
    repeat (12) build_and_judge(10);
  endtask

  task automatic compare_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_side
    verdict_t want;
    logic     next_ready;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no evaluate request pending");
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        compare_field("is_euler", want.is_euler, result_ch.is_euler);
        compare_field("connected", want.connected, result_ch.connected);
        compare_field("all_even", want.all_even, result_ch.all_even);
        compare_field("bad_edge_seen", want.bad_edge_seen, result_ch.bad_edge_seen);
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (pause_left != 0) begin
      pause_left--;
      next_ready = 1'b0;
    end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
      pause_left = $urandom_range(0, 18);
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    result_ch.ready <= next_ready;
  end

  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    request_ch.valid    = 1'b0;
    request_ch.req_type = REQ_CLEAR;
    request_ch.vertex_a = '0;
    request_ch.vertex_b = '0;
    foreach (link_rows[i]) link_rows[i] = '0;
    stray_edge_seen = 1'b0;
    cfg_vertices = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settle_idle();
    test_empty_graph();
    test_self_loops_at_limit();
    test_shrunk_count();
    test_full_size();
    test_result_backpressure();
    test_random_graphs();
    test_steady_stream();
    settle_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
